FILE: rtl/tst_pkg.sv
// Shared types, codes, constants and level/score helpers of the trust score table.
package tst_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 128;
   localparam int VIOLATION_PENALTY   = 50;

   localparam logic [9:0] SCORE_MAX    = 10'd1000;
   localparam logic [9:0] SCORE_LEVEL1 = 10'd200;
   localparam logic [9:0] SCORE_LEVEL2 = 10'd400;
   localparam logic [9:0] SCORE_LEVEL3 = 10'd600;
   localparam logic [9:0] SCORE_LEVEL4 = 10'd900;
   localparam logic [9:0] SCORE_STEP   = 10'd200;
   localparam logic [2:0] LEVEL_MAX    = 3'd4;

   typedef enum logic [2:0] {
      OP_REGISTER  = 3'd0,
      OP_VIOLATION = 3'd1,
      OP_GOOD      = 3'd2,
      OP_ELEVATE   = 3'd3,
      OP_DEMOTE    = 3'd4,
      OP_QUERY     = 3'd5
   } tst_op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } tst_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } tst_state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] subject_id;
      logic [2:0]  level_arg;
      logic [15:0] amount;
   } tst_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        allowed;
      logic [2:0]  level;
      logic [9:0]  score;
      logic [31:0] violation_count;
      logic [31:0] good_count;
      logic [31:0] elevation_total;
      logic [31:0] demotion_total;
      logic [31:0] recalc_total;
      logic [7:0]  entries_used;
   } tst_rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [2:0]  level;
      logic [9:0]  score;
      logic [31:0] violations;
      logic [31:0] goods;
   } tst_entry_type;

   typedef struct packed {
      logic elevate;
      logic demote;
      logic recalc;
      logic allowed;
   } tst_update_flags_type;

   function automatic logic [2:0] sat_level(input logic [2:0] lvl);
      return (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
   endfunction

   function automatic logic [9:0] level_score(input logic [2:0] lvl);
      logic [9:0] s;
      case (lvl)
         3'd0:    s = 10'd0;
         3'd1:    s = SCORE_STEP;
         3'd2:    s = 10'(2 * SCORE_STEP);
         3'd3:    s = 10'(3 * SCORE_STEP);
         default: s = 10'(4 * SCORE_STEP);
      endcase
      return s;
   endfunction

   function automatic logic [2:0] score_to_level(input logic [9:0] s);
      logic [2:0] lvl;
      if (s < SCORE_LEVEL1)      lvl = 3'd0;
      else if (s < SCORE_LEVEL2) lvl = 3'd1;
      else if (s < SCORE_LEVEL3) lvl = 3'd2;
      else if (s < SCORE_LEVEL4) lvl = 3'd3;
      else                       lvl = 3'd4;
      return lvl;
   endfunction

endpackage

FILE: rtl/tst_entry_ram.sv
// Entity table memory: one write port, one registered read port.
module tst_entry_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  tst_pkg::tst_entry_type wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output tst_pkg::tst_entry_type rd_data
);
   import tst_pkg::*;

   tst_entry_type mem [DEPTH];
   tst_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tst_update.sv
// Entry update unit: applies one request to a matched entry and reports counter events.
module tst_update (
   input  tst_pkg::tst_entry_type        entry_in,
   input  tst_pkg::tst_req_type          req,
   output tst_pkg::tst_entry_type        entry_out,
   output tst_pkg::tst_update_flags_type flags
);
   import tst_pkg::*;

   logic [21:0] penalty;
   logic [16:0] sum;
   logic [2:0]  lsat;
   logic [2:0]  score_lvl;

   assign penalty = 22'(req.amount) * 22'(VIOLATION_PENALTY);
   assign sum     = 17'(entry_in.score) + 17'(req.amount);
   assign lsat    = sat_level(req.level_arg);

   always_comb begin
      entry_out = entry_in;
      flags     = '0;
      score_lvl = 3'd0;
      case (req.opcode)
         OP_VIOLATION: begin
            entry_out.violations = entry_in.violations + 32'd1;
            if (22'(entry_in.score) > penalty) begin
               entry_out.score = entry_in.score - penalty[9:0];
            end else begin
               entry_out.score = 10'd0;
            end
            flags.recalc = 1'b1;
         end
         OP_GOOD: begin
            entry_out.goods = entry_in.goods + 32'd1;
            if (entry_in.score < SCORE_MAX) begin
               entry_out.score = (sum > 17'(SCORE_MAX)) ? SCORE_MAX : sum[9:0];
            end
            flags.recalc = 1'b1;
         end
         OP_ELEVATE: begin
            if (lsat > entry_in.level) begin
               entry_out.level = lsat;
               entry_out.score = level_score(lsat);
               flags.elevate   = 1'b1;
            end
         end
         OP_DEMOTE: begin
            if (lsat < entry_in.level) begin
               entry_out.level = lsat;
               entry_out.score = level_score(lsat);
               flags.demote    = 1'b1;
            end
         end
         OP_QUERY: begin
            flags.allowed = (entry_in.level >= req.level_arg);
         end
         default: begin
         end
      endcase
      if (flags.recalc) begin
         score_lvl       = score_to_level(entry_out.score);
         flags.elevate   = (score_lvl > entry_in.level);
         flags.demote    = (score_lvl < entry_in.level);
         entry_out.level = score_lvl;
      end
   end

endmodule

FILE: rtl/trust_score_table_core.sv
// Trust score table top level: request sequencer, table scan and global counters.
//
//   channel | ports              | direction | payload
//   --------+--------------------+-----------+-------------------------
//   request | req_valid/req_stall| in        | tst_req_type  (req_data)
//   result  | rsp_valid/rsp_stall| out       | tst_rsp_type  (rsp_data)
//
// Register and unused opcodes finish in the accept cycle; the result shows in
// the next cycle. Lookup opcodes scan the table one entry a cycle through the
// memory read port and then report the matching entry or a miss.
// One request at a time: req_stall stays high until the result is taken.
// Reset clears the fill count and the global counters; table words are not cleared.
// rsp_stall holds the result; nothing else is affected.
module trust_score_table_core #(
   parameter int MAX_ENTRIES = tst_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tst_pkg::tst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tst_pkg::tst_rsp_type rsp_data
);
   import tst_pkg::*;

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   tst_state_type        state_ff, state_in;
   tst_req_type          req_ff, req_in;
   tst_rsp_type          rsp_ff, rsp_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [IW-1:0]        pend_idx_ff, pend_idx_in;
   logic [CW-1:0]        used_ff, used_in;
   logic [31:0]          elev_ff, elev_in;
   logic [31:0]          dem_ff, dem_in;
   logic [31:0]          recalc_ff, recalc_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   tst_entry_type        wr_data;
   logic                 rd_en;
   tst_entry_type        rd_entry;
   tst_entry_type        upd_entry;
   tst_update_flags_type upd_flags;
   logic [2:0]           lsat_req;
   logic                 table_full;
   logic                 key_match;

   tst_entry_ram #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IW-1:0]),
      .rd_data (rd_entry)
   );

   tst_update u_update (
      .entry_in  (rd_entry),
      .req       (req_ff),
      .entry_out (upd_entry),
      .flags     (upd_flags)
   );

   assign lsat_req   = sat_level(req_data.level_arg);
   assign table_full = (used_ff >= CW'(MAX_ENTRIES));
   assign key_match  = pend_vld_ff && (rd_entry.key == req_ff.subject_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_vld_ff <= 1'b0;
         used_ff     <= '0;
         elev_ff     <= '0;
         dem_ff      <= '0;
         recalc_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         used_ff     <= used_in;
         elev_ff     <= elev_in;
         dem_ff      <= dem_in;
         recalc_ff   <= recalc_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      scan_in     = scan_ff;
      pend_vld_in = 1'b0;
      pend_idx_in = pend_idx_ff;
      used_in     = used_ff;
      elev_in     = elev_ff;
      dem_in      = dem_ff;
      recalc_in   = recalc_ff;
      wr_en       = 1'b0;
      wr_addr     = used_ff[IW-1:0];
      rd_en       = 1'b0;
      wr_data.key        = req_data.subject_id;
      wr_data.level      = lsat_req;
      wr_data.score      = level_score(lsat_req);
      wr_data.violations = 32'd0;
      wr_data.goods      = 32'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in                 = req_data;
               scan_in                = '0;
               rsp_in                 = '0;
               rsp_in.status          = STATUS_OK;
               rsp_in.elevation_total = elev_ff;
               rsp_in.demotion_total  = dem_ff;
               rsp_in.recalc_total    = recalc_ff;
               rsp_in.entries_used    = 8'(used_ff);
               case (req_data.opcode)
                  OP_REGISTER: begin
                     if (table_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        wr_en               = 1'b1;
                        used_in             = used_ff + CW'(1);
                        rsp_in.level        = lsat_req;
                        rsp_in.score        = level_score(lsat_req);
                        rsp_in.entries_used = 8'(used_ff + CW'(1));
                     end
                     state_in = ST_RESP;
                  end
                  OP_VIOLATION, OP_GOOD, OP_ELEVATE, OP_DEMOTE, OP_QUERY: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               state_in = ST_UPDATE;
            end else if (scan_ff < used_ff) begin
               rd_en       = 1'b1;
               pend_vld_in = 1'b1;
               pend_idx_in = scan_ff[IW-1:0];
               scan_in     = scan_ff + CW'(1);
            end else if (!pend_vld_ff) begin
               rsp_in.status  = STATUS_NOT_FOUND;
               rsp_in.allowed = (req_ff.opcode == OP_QUERY) && (req_ff.level_arg == 3'd0);
               state_in       = ST_RESP;
            end
         end
         ST_UPDATE: begin
            wr_en                  = 1'b1;
            wr_addr                = pend_idx_ff;
            wr_data                = upd_entry;
            elev_in                = elev_ff + 32'(upd_flags.elevate);
            dem_in                 = dem_ff + 32'(upd_flags.demote);
            recalc_in              = recalc_ff + 32'(upd_flags.recalc);
            rsp_in.status          = STATUS_OK;
            rsp_in.allowed         = upd_flags.allowed;
            rsp_in.level           = upd_entry.level;
            rsp_in.score           = upd_entry.score;
            rsp_in.violation_count = upd_entry.violations;
            rsp_in.good_count      = upd_entry.goods;
            rsp_in.elevation_total = elev_ff + 32'(upd_flags.elevate);
            rsp_in.demotion_total  = dem_ff + 32'(upd_flags.demote);
            rsp_in.recalc_total    = recalc_ff + 32'(upd_flags.recalc);
            state_in               = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/tst_checker.sv
// Port-level checker for the trust score table and its bind to the top level.
module tst_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input tst_pkg::tst_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input tst_pkg::tst_rsp_type rsp_data
);
   import tst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid)
      else $error("request accepted while a result is pending");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_NOT_FOUND) |->
      (rsp_data.level == 3'd0) && (rsp_data.score == 10'd0) &&
      (rsp_data.violation_count == 32'd0) && (rsp_data.good_count == 32'd0))
      else $error("unknown entity reported nonzero entry fields");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.score <= SCORE_MAX) && (rsp_data.level <= LEVEL_MAX) &&
      (rsp_data.level == score_to_level(rsp_data.score) ||
       rsp_data.status != STATUS_OK || rsp_data.score == level_score(rsp_data.level)))
      else $error("result score or level out of range");

endmodule

bind trust_score_table_core tst_checker u_tst_checker (.*);

FILE: test/tb_trust_score_table_core.sv
// Testbench for the trust score table core: directed and random requests checked against a predictor.
module tb_trust_score_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   import tst_pkg::*;

   localparam int TABLE_DEPTH = MAX_ENTRIES_DEFAULT;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 20;
   localparam int HOLD_OFF_LEN = 400;
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tst_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tst_rsp_type rsp_data;

   // trust table shadow
   logic [31:0] tbl_key [TABLE_DEPTH];
   logic [2:0] tbl_level [TABLE_DEPTH];
   logic [9:0] tbl_score [TABLE_DEPTH];
   logic [31:0] tbl_viol [TABLE_DEPTH];
   logic [31:0] tbl_good [TABLE_DEPTH];
   int unsigned tbl_used = 0;
   logic [31:0] elev_total = '0;
   logic [31:0] demo_total = '0;
   logic [31:0] recalc_total = '0;

   tst_rsp_type expected_results[$];
   tst_rsp_type oldest_expected;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_cycles = 0;
   int idle_cycles = 0;
   int mismatch_count = 0;
   int results_checked = 0;
   int requests_sent = 0;
   int full_rejects = 0;
   int lookup_misses = 0;

   trust_score_table_core #(.MAX_ENTRIES(TABLE_DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   function automatic logic [2:0] level_for_score(input logic [9:0] s);
      logic [2:0] lvl;
      lvl = 3'd0;
      if (s >= SCORE_LEVEL1) lvl = 3'd1;
      if (s >= SCORE_LEVEL2) lvl = 3'd2;
      if (s >= SCORE_LEVEL3) lvl = 3'd3;
      if (s >= SCORE_LEVEL4) lvl = 3'd4;
      return lvl;
   endfunction

   function automatic int find_entity(input logic [31:0] id);
      for (int i = 0; i < tbl_used; i++) begin
         if (tbl_key[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void rescore_entity(input int idx);
      logic [2:0] nl;
      nl = level_for_score(tbl_score[idx]);
      if (nl > tbl_level[idx]) elev_total = elev_total + 1;
      else if (nl < tbl_level[idx]) demo_total = demo_total + 1;
      tbl_level[idx] = nl;
      recalc_total = recalc_total + 1;
   endfunction

   function automatic tst_rsp_type predict_trust(input tst_req_type r);
      tst_rsp_type rsp;
      int idx;
      logic [2:0] lsat;
      int unsigned penalty;
      int unsigned sum;
      rsp = '0;
      idx = -1;
      lsat = (r.level_arg > LEVEL_MAX) ? LEVEL_MAX : r.level_arg;
      case (r.opcode)
         OP_REGISTER: begin
            if (tbl_used >= TABLE_DEPTH) begin
               rsp.status = STATUS_FULL;
               full_rejects++;
            end else begin
               idx = tbl_used;
               tbl_key[idx] = r.subject_id;
               tbl_level[idx] = lsat;
               tbl_score[idx] = 10'(lsat * SCORE_STEP);
               tbl_viol[idx] = '0;
               tbl_good[idx] = '0;
               tbl_used++;
            end
         end
         OP_VIOLATION, OP_GOOD, OP_ELEVATE, OP_DEMOTE, OP_QUERY: begin
            idx = find_entity(r.subject_id);
            if (idx < 0) begin
               rsp.status = STATUS_NOT_FOUND;
               lookup_misses++;
               if (r.opcode == OP_QUERY) rsp.allowed = (r.level_arg == 3'd0);
            end else begin
               case (r.opcode)
                  OP_VIOLATION: begin
                     penalty = r.amount * VIOLATION_PENALTY;
                     tbl_viol[idx] = tbl_viol[idx] + 1;
                     tbl_score[idx] = (tbl_score[idx] > penalty) ?
                                      10'(tbl_score[idx] - penalty) : 10'd0;
                     rescore_entity(idx);
                  end
                  OP_GOOD: begin
                     tbl_good[idx] = tbl_good[idx] + 1;
                     if (tbl_score[idx] < SCORE_MAX) begin
                        sum = tbl_score[idx] + r.amount;
                        tbl_score[idx] = (sum > SCORE_MAX) ? SCORE_MAX : 10'(sum);
                     end
                     rescore_entity(idx);
                  end
                  OP_ELEVATE: begin
                     if (lsat > tbl_level[idx]) begin
                        tbl_level[idx] = lsat;
                        tbl_score[idx] = 10'(lsat * SCORE_STEP);
                        elev_total = elev_total + 1;
                     end
                  end
                  OP_DEMOTE: begin
                     if (lsat < tbl_level[idx]) begin
                        tbl_level[idx] = lsat;
                        tbl_score[idx] = 10'(lsat * SCORE_STEP);
                        demo_total = demo_total + 1;
                     end
                  end
                  default: begin
                     rsp.allowed = (tbl_level[idx] >= r.level_arg);
                  end
               endcase
            end
         end
         default: ;
      endcase
      if (idx >= 0) begin
         rsp.level = tbl_level[idx];
         rsp.score = tbl_score[idx];
         rsp.violation_count = tbl_viol[idx];
         rsp.good_count = tbl_good[idx];
      end
      rsp.elevation_total = elev_total;
      rsp.demotion_total = demo_total;
      rsp.recalc_total = recalc_total;
      rsp.entries_used = 8'(tbl_used);
      return rsp;
   endfunction

   function automatic tst_req_type make_request(input logic [2:0] op, input logic [31:0] id,
                                                input logic [2:0] lvl, input logic [15:0] amt);
      tst_req_type r;
      r.opcode = op;
      r.subject_id = id;
      r.level_arg = lvl;
      r.amount = amt;
      return r;
   endfunction

   function automatic logic [31:0] known_id();
      return tbl_key[$urandom_range(tbl_used - 1)];
   endfunction

   function automatic tst_req_type random_request();
      int unsigned pick;
      logic [2:0] op;
      logic [31:0] id;
      logic [2:0] lvl;
      logic [15:0] amt;
      pick = $urandom_range(99);
      if (pick < 15) op = OP_REGISTER;
      else if (pick < 35) op = OP_VIOLATION;
      else if (pick < 55) op = OP_GOOD;
      else if (pick < 67) op = OP_ELEVATE;
      else if (pick < 79) op = OP_DEMOTE;
      else if (pick < 95) op = OP_QUERY;
      else op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      if (op == OP_REGISTER)
         id = (tbl_used > 0 && $urandom_range(99) < 25) ? known_id() : $urandom;
      else
         id = (tbl_used > 0 && $urandom_range(99) < 85) ? known_id() : $urandom;
      lvl = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      if ($urandom_range(9) == 0) amt = 16'($urandom);
      else if (op == OP_VIOLATION) amt = 16'($urandom_range(8));
      else if (op == OP_GOOD) amt = 16'($urandom_range(300));
      else amt = 16'($urandom);
      return make_request(op, id, lvl, amt);
   endfunction

   task automatic send_request(input tst_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_results.push_back(predict_trust(r));
      requests_sent++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            check_field("status", oldest_expected.status, rsp_data.status);
            check_field("allowed", oldest_expected.allowed, rsp_data.allowed);
            check_field("level", oldest_expected.level, rsp_data.level);
            check_field("score", oldest_expected.score, rsp_data.score);
            check_field("violation_count", oldest_expected.violation_count,
                        rsp_data.violation_count);
            check_field("good_count", oldest_expected.good_count, rsp_data.good_count);
            check_field("elevation_total", oldest_expected.elevation_total,
                        rsp_data.elevation_total);
            check_field("demotion_total", oldest_expected.demotion_total,
                        rsp_data.demotion_total);
            check_field("recalc_total", oldest_expected.recalc_total, rsp_data.recalc_total);
            check_field("entries_used", oldest_expected.entries_used, rsp_data.entries_used);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles at %0t", IDLE_LIMIT, $time);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic test_directed_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(make_request(OP_QUERY, 32'h0000_0000, 3'd0, 16'h0000));
      send_request(make_request(OP_QUERY, 32'hDEAD_BEEF, 3'd3, 16'h0000));
      send_request(make_request(OP_VIOLATION, 32'h0000_0000, 3'd0, 16'h0005));
      send_request(make_request(OP_ELEVATE, 32'hFFFF_FFFF, 3'd4, 16'h0000));
      send_request(make_request(OP_REGISTER, 32'h0000_0000, 3'd0, 16'hFFFF));
      send_request(make_request(OP_REGISTER, 32'hFFFF_FFFF, 3'd7, 16'h0000));
      send_request(make_request(OP_REGISTER, 32'h0000_1234, 3'd2, 16'h0000));
      send_request(make_request(OP_REGISTER, 32'h0000_1234, 3'd4, 16'h0000));
      send_request(make_request(OP_QUERY, 32'h0000_1234, 3'd3, 16'h0000));
      send_request(make_request(OP_QUERY, 32'hFFFF_FFFF, 3'd4, 16'h0000));
      send_request(make_request(OP_QUERY, 32'hFFFF_FFFF, 3'd5, 16'h0000));
      send_request(make_request(OP_QUERY, 32'hFFFF_FFFF, 3'd7, 16'h0000));
      send_request(make_request(OP_VIOLATION, 32'h0000_0000, 3'd0, 16'h0000));
      send_request(make_request(OP_VIOLATION, 32'hFFFF_FFFF, 3'd0, 16'hFFFF));
      send_request(make_request(OP_GOOD, 32'h0000_0000, 3'd0, 16'hFFFF));
      send_request(make_request(OP_GOOD, 32'h0000_0000, 3'd0, 16'h0001));
      send_request(make_request(OP_GOOD, 32'h0000_1234, 3'd0, 16'd199));
      send_request(make_request(OP_GOOD, 32'h0000_1234, 3'd0, 16'd1));
      send_request(make_request(OP_VIOLATION, 32'h0000_1234, 3'd0, 16'd1));
      send_request(make_request(OP_ELEVATE, 32'h0000_1234, 3'd2, 16'h0000));
      send_request(make_request(OP_ELEVATE, 32'h0000_1234, 3'd7, 16'h0000));
      send_request(make_request(OP_DEMOTE, 32'h0000_1234, 3'd6, 16'h0000));
      send_request(make_request(OP_DEMOTE, 32'h0000_1234, 3'd0, 16'h0000));
      send_request(make_request(OP_UNUSED_LO, 32'hA5A5_5A5A, 3'd7, 16'hFFFF));
      send_request(make_request(OP_UNUSED_HI, 32'h5A5A_A5A5, 3'd0, 16'h0000));
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_request(random_request());
   endtask

   task automatic test_result_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (8) send_request(random_request());
   endtask

   task automatic test_table_full();
      send_idle_pct = 0;
      rsp_stall_pct = 29;
      while (tbl_used < TABLE_DEPTH)
         send_request(make_request(OP_REGISTER, $urandom, 3'($urandom_range(7)), 16'($urandom)));
      repeat (3)
         send_request(make_request(OP_REGISTER, $urandom, 3'($urandom_range(7)), 16'($urandom)));
      send_request(make_request(OP_QUERY, tbl_key[TABLE_DEPTH - 1], 3'd0, 16'h0000));
      send_request(make_request(OP_GOOD, tbl_key[TABLE_DEPTH - 1], 3'd0, 16'd250));
      send_request(make_request(OP_QUERY, $urandom, 3'd1, 16'h0000));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(80, 0, 0);
      test_random_traffic(80, 64, 0);
      test_result_backpressure();
      test_table_full();
      test_random_traffic(80, 0, 64);
      test_random_traffic(80, 29, 29);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over all opcodes; %0d results checked, %0d mismatches.",
               requests_sent, results_checked, mismatch_count);
      $display("Table reached %0d entries; %0d registrations hit a full table, %0d lookups missed.",
               tbl_used, full_rejects, lookup_misses);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: trust_score_table_core.f
rtl/tst_pkg.sv
rtl/tst_entry_ram.sv
rtl/tst_update.sv
rtl/trust_score_table_core.sv
rtl/tst_checker.sv
test/tb_trust_score_table_core.sv
